@@ rtl/hlwg_pkg.sv @@
// Shared types, constants, coefficient table and microcode program of the haptic low-pass gate.
package hlwg_pkg;

   // Default parameters of the top level
   localparam int STAGE_COUNT_DEF = 4;
   localparam int COEF_FRAC_DEF   = 30;

   // Fixed widths of the datapath
   localparam int SAMPLE_W   = 16;
   localparam int HIST_W     = 48;
   localparam int STATE_FRAC = 16;
   localparam int CHUNK_W    = HIST_W / 2;
   localparam int ACC_W      = HIST_W + 4;
   localparam int TABLE_FRAC = 40;
   localparam int MARGIN_W   = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd8000;
   localparam logic [SAMPLE_W-1:0] SIGN_FLIP    = 16'h8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MUSIC_ENABLE  = 1'b0,
      REG_WINDOW_MARGIN = 1'b1
   } csr_index_type;

   // Microcode fields
   typedef enum logic [2:0] {
      COEF_G, COEF_G2, COEF_A1, COEF_A2, COEF_OUT
   } coef_kind_type;

   typedef enum logic [1:0] {
      HIST_X1, HIST_X2, HIST_Y1, HIST_Y2
   } hist_slot_type;

   typedef enum logic {
      SRC_X, SRC_RD
   } opnd_src_type;

   typedef enum logic [1:0] {
      ALU_NONE, ALU_SAT, ALU_OFFSET, ALU_GATE
   } alu_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT, SEQ_STAGE_LOOP, SEQ_FINISH
   } seq_op_type;

   typedef struct packed {
      logic          rd_en;
      hist_slot_type rd_slot;
      logic          wr_en;
      hist_slot_type wr_slot;
      opnd_src_type  wr_src;
      logic          mul_en;
      logic          mul_hi;
      opnd_src_type  mul_src;
      coef_kind_type coef;
      logic          acc_add;
      alu_op_type    alu;
      seq_op_type    seq;
   } ucode_type;

   localparam ucode_type UC_NOP = '0;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd18;

   // Per stage, 40 fraction bits: numerator gain g, a1, a2
   localparam logic signed [63:0] COEF_T40 [4][3] = '{
      '{64'sd67387592, 64'sd2197545158462, -64'sd1098303081055},
      '{64'sd48996230, 64'sd2195389054896, -64'sd1096073412039},
      '{64'sd23064643, 64'sd2193789214659, -64'sd1094369845456},
      '{64'sd4752391,  64'sd2192941544952, -64'sd1093448926739}
   };
   localparam logic signed [63:0] OUT_GAIN_T40 = 64'sd979940769745;

   // Round the magnitude half up to frac fraction bits
   function automatic logic signed [63:0] to_coef(logic signed [63:0] c40, int frac);
      logic        neg;
      logic [63:0] mag;
      int          s;
      neg = c40[63];
      mag = neg ? 64'(-c40) : 64'(c40);
      s   = TABLE_FRAC - frac;
      if (s > 0) begin
         mag = (mag + (64'd1 << (s - 1))) >> s;
      end
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   // Coefficient for a stage set and a term kind
   function automatic logic signed [63:0] coef_value(logic [1:0] set, coef_kind_type kind,
                                                      int frac);
      logic signed [63:0] r;
      r = '0;
      unique case (kind)
         COEF_G:   r = to_coef(COEF_T40[set][0], frac);
         COEF_G2:  r = to_coef(COEF_T40[set][0], frac) <<< 1;
         COEF_A1:  r = to_coef(COEF_T40[set][1], frac);
         COEF_A2:  r = to_coef(COEF_T40[set][2], frac);
         COEF_OUT: r = to_coef(OUT_GAIN_T40, frac);
         default:  r = '0;
      endcase
      return r;
   endfunction

   // Control store: steps 0..13 run one stage, 14..18 scale and gate the output
   function automatic ucode_type ucode_rom(logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = UC_NOP;
      unique case (step)
         5'd0: begin
            uc.rd_en = 1'b1; uc.rd_slot = HIST_X2;
         end
         5'd1: begin
            uc.mul_en = 1'b1; uc.mul_src = SRC_RD; uc.coef = COEF_G;
         end
         5'd2: begin
            uc.mul_en = 1'b1; uc.mul_hi = 1'b1; uc.mul_src = SRC_RD; uc.coef = COEF_G;
            uc.rd_en = 1'b1; uc.rd_slot = HIST_X1;
         end
         5'd3: begin
            uc.acc_add = 1'b1;
            uc.mul_en = 1'b1; uc.mul_src = SRC_RD; uc.coef = COEF_G2;
            uc.wr_en = 1'b1; uc.wr_slot = HIST_X2; uc.wr_src = SRC_RD;
         end
         5'd4: begin
            uc.mul_en = 1'b1; uc.mul_hi = 1'b1; uc.mul_src = SRC_RD; uc.coef = COEF_G2;
            uc.rd_en = 1'b1; uc.rd_slot = HIST_Y2;
            uc.wr_en = 1'b1; uc.wr_slot = HIST_X1; uc.wr_src = SRC_X;
         end
         5'd5: begin
            uc.acc_add = 1'b1;
            uc.mul_en = 1'b1; uc.mul_src = SRC_RD; uc.coef = COEF_A2;
         end
         5'd6: begin
            uc.mul_en = 1'b1; uc.mul_hi = 1'b1; uc.mul_src = SRC_RD; uc.coef = COEF_A2;
            uc.rd_en = 1'b1; uc.rd_slot = HIST_Y1;
         end
         5'd7: begin
            uc.acc_add = 1'b1;
            uc.mul_en = 1'b1; uc.mul_src = SRC_RD; uc.coef = COEF_A1;
         end
         5'd8: begin
            uc.mul_en = 1'b1; uc.mul_hi = 1'b1; uc.mul_src = SRC_RD; uc.coef = COEF_A1;
            uc.wr_en = 1'b1; uc.wr_slot = HIST_Y2; uc.wr_src = SRC_RD;
         end
         5'd9: begin
            uc.acc_add = 1'b1;
            uc.mul_en = 1'b1; uc.mul_src = SRC_X; uc.coef = COEF_G;
         end
         5'd10: begin
            uc.mul_en = 1'b1; uc.mul_hi = 1'b1; uc.mul_src = SRC_X; uc.coef = COEF_G;
         end
         5'd11: begin
            uc.acc_add = 1'b1;
         end
         5'd12: begin
            uc.alu = ALU_SAT;
         end
         5'd13: begin
            uc.wr_en = 1'b1; uc.wr_slot = HIST_Y1; uc.wr_src = SRC_X;
            uc.seq = SEQ_STAGE_LOOP;
         end
         5'd14: begin
            uc.mul_en = 1'b1; uc.mul_src = SRC_X; uc.coef = COEF_OUT;
         end
         5'd15: begin
            uc.mul_en = 1'b1; uc.mul_hi = 1'b1; uc.mul_src = SRC_X; uc.coef = COEF_OUT;
         end
         5'd16: begin
            uc.acc_add = 1'b1;
         end
         5'd17: begin
            uc.alu = ALU_OFFSET;
         end
         5'd18: begin
            uc.alu = ALU_GATE; uc.seq = SEQ_FINISH;
         end
         default: uc = UC_NOP;
      endcase
      return uc;
   endfunction

endpackage

@@ rtl/haptic_lowpass_window_gate.sv @@
// Top level: stream ports, configuration registers and microcode sequencer.
//
// Each 16-bit sample word has its offset flipped, passes a cascade of STAGE_COUNT
// direct-form-I biquad low-pass stages whose history persists across words, is scaled,
// re-offset, zeroed outside the window set by window_margin and forced to zero while
// music_enable is low. One word is in work at a time: after a word is taken the block is
// busy and can take the next word in the cycle after its result is loaded. Its pace is
// set by the single shared multiplier, which forms each of the five products of a stage
// in two half-width passes, and by the one-read, one-write history memory that the control
// program steps through. The result sits in an output register, so a new word is accepted
// while the previous result waits; only when a finished result finds that register still
// full does the program hold on its last step. The filter history is cleared by reset and
// needs no pass.
module haptic_lowpass_window_gate #(
   parameter int STAGE_COUNT    = hlwg_pkg::STAGE_COUNT_DEF,
   parameter int COEF_FRAC_BITS = hlwg_pkg::COEF_FRAC_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // [15:0] sample_in
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [15:0] drive_out
   // Configuration writes
   input  logic                                csr_we,
   input  logic [hlwg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hlwg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int STG_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
   localparam int STEP_W = hlwg_pkg::STEP_W;
   localparam logic [STG_W-1:0] LAST_STAGE = STG_W'(STAGE_COUNT - 1);

   logic                                music_enable_ff;
   logic [hlwg_pkg::MARGIN_W-1:0]       window_margin_ff;
   logic                                busy_ff;
   logic [STEP_W-1:0]                   step_ff;
   logic [STG_W-1:0]                    stage_ff;
   logic                                rsp_tvalid_ff;
   logic [15:0]                         rsp_tdata_ff;

   hlwg_pkg::ucode_type                 uc_act;
   logic                                load;
   logic                                out_free;
   logic                                finish_fire;
   logic [hlwg_pkg::SAMPLE_W-1:0]       drive;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         music_enable_ff  <= 1'b0;
         window_margin_ff <= hlwg_pkg::MARGIN_RESET;
      end else if (csr_we) begin
         unique case (hlwg_pkg::csr_index_type'(csr_index))
            hlwg_pkg::REG_MUSIC_ENABLE:  music_enable_ff  <= csr_wdata[0];
            hlwg_pkg::REG_WINDOW_MARGIN: window_margin_ff <= csr_wdata;
         endcase
      end
   end

   // Fetch the control word; idle issues no operations
   assign uc_act      = busy_ff ? hlwg_pkg::ucode_rom(step_ff) : hlwg_pkg::UC_NOP;
   assign load        = req_tvalid && !busy_ff;
   assign out_free    = !rsp_tvalid_ff || rsp_tready;
   assign finish_fire = (uc_act.seq == hlwg_pkg::SEQ_FINISH) && out_free;

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Sequencer: step counter, stage loop and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         step_ff       <= '0;
         stage_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // set valid on a finished word, drop it once the word is taken
         if (finish_fire) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (load) begin
            busy_ff  <= 1'b1;
            step_ff  <= '0;
            stage_ff <= '0;
         end else if (busy_ff) begin
            unique case (uc_act.seq)
               hlwg_pkg::SEQ_NEXT: begin
                  step_ff <= step_ff + STEP_W'(1);
               end
               hlwg_pkg::SEQ_STAGE_LOOP: begin
                  if (stage_ff == LAST_STAGE) begin
                     step_ff <= step_ff + STEP_W'(1);
                  end else begin
                     step_ff  <= '0;
                     stage_ff <= stage_ff + STG_W'(1);
                  end
               end
               hlwg_pkg::SEQ_FINISH: begin
                  // hold on the last step until the output register is free
                  if (out_free) begin
                     busy_ff      <= 1'b0;
                     rsp_tdata_ff <= drive;
                  end
               end
               default: begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            endcase
         end
      end
   end

   hlwg_datapath #(
      .STAGE_COUNT    (STAGE_COUNT),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .STG_W          (STG_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .sample        (req_tdata),
      .uc            (uc_act),
      .stage_idx     (stage_ff),
      .music_enable  (music_enable_ff),
      .window_margin (window_margin_ff),
      .drive         (drive)
   );

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (busy_ff && step_ff == '0 && stage_ff == '0))
      else $error("accepted word did not start the program at step zero");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= hlwg_pkg::LAST_STEP))
      else $error("step counter ran past the program");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (stage_ff <= LAST_STAGE))
      else $error("stage counter ran past the cascade");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      finish_fire |=> (rsp_tvalid && !busy_ff))
      else $error("finished word did not reach the output register");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (!uc_act.wr_en && !uc_act.mul_en && !uc_act.acc_add))
      else $error("datapath active while idle");
`endif

endmodule

@@ rtl/hlwg_datapath.sv @@
// Filter datapath: shared multiplier, accumulator, history memory and output gate.
module hlwg_datapath #(
   parameter int STAGE_COUNT    = hlwg_pkg::STAGE_COUNT_DEF,
   parameter int COEF_FRAC_BITS = hlwg_pkg::COEF_FRAC_DEF,
   parameter int STG_W          = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [hlwg_pkg::SAMPLE_W-1:0]      sample,
   input  hlwg_pkg::ucode_type                uc,
   input  logic [STG_W-1:0]                   stage_idx,
   input  logic                               music_enable,
   input  logic [hlwg_pkg::MARGIN_W-1:0]      window_margin,
   output logic [hlwg_pkg::SAMPLE_W-1:0]      drive
);

   localparam int HIST_W  = hlwg_pkg::HIST_W;
   localparam int ACC_W   = hlwg_pkg::ACC_W;
   localparam int CHUNK_W = hlwg_pkg::CHUNK_W;
   localparam int SFRAC   = hlwg_pkg::STATE_FRAC;
   localparam int SW      = hlwg_pkg::SAMPLE_W;
   localparam int COEF_W  = COEF_FRAC_BITS + 2;
   localparam int PP_W    = CHUNK_W + 1 + COEF_W;
   localparam int PROD_W  = HIST_W + COEF_W;
   localparam int TERM_W  = PROD_W - COEF_FRAC_BITS;
   localparam int DEPTH   = 4 * STAGE_COUNT;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam logic signed [ACC_W-1:0] HIST_MAX_A =
      $signed(ACC_W'({1'b0, {(HIST_W-1){1'b1}}}));
   localparam logic signed [ACC_W-1:0] HIST_MIN_A = -HIST_MAX_A - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] HALF_SCALE = $signed(ACC_W'(64'd32768 << SFRAC));
   localparam logic signed [ACC_W-1:0] FULL_SCALE = $signed(ACC_W'(64'd65536 << SFRAC));

   logic signed [HIST_W-1:0] x_ff, x_in;
   logic signed [HIST_W-1:0] rd_data_ff;
   logic signed [HIST_W-1:0] hist_mem_ff [DEPTH];
   logic [DEPTH-1:0]         hist_vld_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic [STG_W+1:0]         rd_full, wr_full;
   logic [ADDR_W-1:0]        rd_addr, wr_addr;
   logic signed [HIST_W-1:0] wr_data;
   logic signed [COEF_W-1:0] coef;
   logic signed [HIST_W-1:0] opnd;
   logic signed [CHUNK_W:0]  chunk;
   logic signed [PP_W-1:0]   pp;
   logic signed [TERM_W-1:0] term;
   logic signed [HIST_W-1:0] sat_val;
   logic signed [ACC_W-1:0]  off_sum;
   logic signed [ACC_W-1:0]  lo_bound, hi_bound;
   logic                     in_win;
   logic [SW:0]              level;

   // History addressing: four slots per stage
   assign rd_full = {stage_idx, uc.rd_slot};
   assign wr_full = {stage_idx, uc.wr_slot};
   assign rd_addr = rd_full[ADDR_W-1:0];
   assign wr_addr = wr_full[ADDR_W-1:0];
   assign wr_data = (uc.wr_src == hlwg_pkg::SRC_RD) ? rd_data_ff : x_ff;

   // History memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (uc.wr_en) begin
         hist_mem_ff[wr_addr] <= wr_data;
      end
      if (uc.rd_en) begin
         rd_data_ff <= hist_vld_ff[rd_addr] ? hist_mem_ff[rd_addr] : '0;
      end
   end

   // Entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
      end else if (uc.wr_en) begin
         hist_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Coefficient lookup, set chosen by stage modulo four
   assign coef = COEF_W'(hlwg_pkg::coef_value(2'(stage_idx), uc.coef, COEF_FRAC_BITS));

   // Shared multiplier: one half of the operand per pass
   assign opnd  = (uc.mul_src == hlwg_pkg::SRC_RD) ? rd_data_ff : x_ff;
   assign chunk = uc.mul_hi ? {opnd[HIST_W-1], opnd[HIST_W-1:CHUNK_W]}
                            : {1'b0, opnd[CHUNK_W-1:0]};
   assign pp    = PP_W'(chunk) * PP_W'(coef);

   always_comb begin
      prod_in = prod_ff;
      if (uc.mul_en) begin
         prod_in = uc.mul_hi ? prod_ff + (PROD_W'(pp) <<< CHUNK_W) : PROD_W'(pp);
      end
   end

   // Floor the exact product to state precision
   assign term = TERM_W'(prod_ff >>> COEF_FRAC_BITS);

   // Saturate the stage sum to the history width
   always_comb begin
      priority if (acc_ff > HIST_MAX_A) begin
         sat_val = HIST_MAX_A[HIST_W-1:0];
      end else if (acc_ff < HIST_MIN_A) begin
         sat_val = HIST_MIN_A[HIST_W-1:0];
      end else begin
         sat_val = acc_ff[HIST_W-1:0];
      end
   end

   assign off_sum = acc_ff + HALF_SCALE;

   // Accumulator and stage input register
   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      if (load) begin
         acc_in = '0;
         x_in   = $signed(HIST_W'({sample ^ hlwg_pkg::SIGN_FLIP, SFRAC'(0)}));
      end else begin
         if (uc.acc_add) begin
            acc_in = acc_ff + ACC_W'(term);
         end
         unique case (uc.alu)
            hlwg_pkg::ALU_SAT: begin
               x_in   = sat_val;
               acc_in = '0;
            end
            hlwg_pkg::ALU_OFFSET: begin
               acc_in = (off_sum > FULL_SCALE) ? off_sum - FULL_SCALE : off_sum;
            end
            hlwg_pkg::ALU_NONE, hlwg_pkg::ALU_GATE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Window gate and enable on the offset level
   assign lo_bound = $signed(ACC_W'(window_margin) << SFRAC);
   assign hi_bound = FULL_SCALE - lo_bound;
   assign in_win   = !(acc_ff[ACC_W-1] || (acc_ff < lo_bound) || (acc_ff > hi_bound));
   assign level    = acc_ff[SFRAC +: SW+1];

   always_comb begin
      drive = '0;
      if (in_win && music_enable) begin
         drive = level[SW] ? {SW{1'b1}} : level[SW-1:0];
      end
   end

endmodule

@@ tb/tb_haptic_lowpass_window_gate.sv @@
// Self-checking testbench for the haptic low-pass window gate: stream stimulus, bit-exact predictor.
`timescale 1ns / 1ps

module tb_haptic_lowpass_window_gate;

   localparam int HALF_PERIOD  = 4;
   localparam int STAGES       = hlwg_pkg::STAGE_COUNT_DEF;
   localparam int COEF_FRAC    = hlwg_pkg::COEF_FRAC_DEF;
   localparam int T40_FRAC     = 40;
   localparam int LIMIT_CYCLES = 1200000;
   localparam int IDLE_SETTLE  = 8;
   localparam int LATENCY_TAIL = 80;

   // History slots of one biquad stage
   localparam int SLOT_X1 = 0;
   localparam int SLOT_X2 = 1;
   localparam int SLOT_Y1 = 2;
   localparam int SLOT_Y2 = 3;

   localparam logic [15:0]        OFFSET_FLIP = 16'h8000;
   localparam logic signed [63:0] HIST_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] HIST_BOTTOM = 64'shFFFF_8000_0000_0000;
   localparam logic signed [63:0] MID_LEVEL   = 64'sd32768 <<< 16;
   localparam logic signed [63:0] FULL_LEVEL  = 64'sd65536 <<< 16;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [15:0]                     req_tdata;   // [15:0] sample_in
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [15:0]                     rsp_tdata;   // [15:0] drive_out
   logic                            csr_we;
   logic [hlwg_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [hlwg_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Predictor state: configuration, coefficients and per-stage history
   logic                  music_on;
   logic [15:0]           margin_reg;
   logic signed [63:0]    gain_q [4];
   logic signed [63:0]    a1_q [4];
   logic signed [63:0]    a2_q [4];
   logic signed [63:0]    out_gain_q;
   logic signed [47:0]    stage_hist [STAGES][4];

   logic [15:0] expected_drive_q [$];
   int          error_count     = 0;
   int          hold_off_cycles = 0;
   int          burst_left      = 0;
   int          cycle_count     = 0;

   haptic_lowpass_window_gate u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Round a 40-fraction-bit constant's magnitude half up to the coefficient format
   function automatic logic signed [63:0] round_coef(logic signed [63:0] c40);
      logic        neg;
      logic [63:0] mag;
      int          sh;
      neg = (c40 < 0);
      mag = neg ? -c40 : c40;
      sh  = T40_FRAC - COEF_FRAC;
      if (sh > 0) begin
         mag = (mag + (64'd1 << (sh - 1))) >> sh;
      end
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   // Exact product, floored to the state format
   function automatic logic signed [63:0] coef_mul(logic signed [63:0] a, logic signed [63:0] c);
      logic signed [127:0] wa;
      logic signed [127:0] wc;
      logic signed [127:0] p;
      wa = a;
      wc = c;
      p  = (wa * wc) >>> COEF_FRAC;
      return p[63:0];
   endfunction

   task automatic reset_predictor();
      int k;
      int j;
      music_on   = 1'b0;
      margin_reg = 16'd8000;
      gain_q[0]  = round_coef(64'sd67387592);
      a1_q[0]    = round_coef(64'sd2197545158462);
      a2_q[0]    = round_coef(-64'sd1098303081055);
      gain_q[1]  = round_coef(64'sd48996230);
      a1_q[1]    = round_coef(64'sd2195389054896);
      a2_q[1]    = round_coef(-64'sd1096073412039);
      gain_q[2]  = round_coef(64'sd23064643);
      a1_q[2]    = round_coef(64'sd2193789214659);
      a2_q[2]    = round_coef(-64'sd1094369845456);
      gain_q[3]  = round_coef(64'sd4752391);
      a1_q[3]    = round_coef(64'sd2192941544952);
      a2_q[3]    = round_coef(-64'sd1093448926739);
      out_gain_q = round_coef(64'sd979940769745);
      for (k = 0; k < STAGES; k++) begin
         for (j = 0; j < 4; j++) begin
            stage_hist[k][j] = '0;
         end
      end
   endtask

   // Run one sample through the cascade, advance the history and gate the output
   function automatic logic [15:0] predict_drive(logic [15:0] sample);
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] g;
      logic signed [63:0] w;
      logic signed [63:0] m;
      logic signed [63:0] v;
      int                 k;
      x = {32'd0, sample ^ OFFSET_FLIP, 16'd0};
      for (k = 0; k < STAGES; k++) begin
         g = gain_q[k % 4];
         y = coef_mul(x, g) + coef_mul(stage_hist[k][SLOT_X1], g <<< 1)
           + coef_mul(stage_hist[k][SLOT_X2], g)
           + coef_mul(stage_hist[k][SLOT_Y1], a1_q[k % 4])
           + coef_mul(stage_hist[k][SLOT_Y2], a2_q[k % 4]);
         if (y > HIST_TOP) begin
            y = HIST_TOP;
         end else if (y < HIST_BOTTOM) begin
            y = HIST_BOTTOM;
         end
         stage_hist[k][SLOT_X2] = stage_hist[k][SLOT_X1];
         stage_hist[k][SLOT_X1] = x[47:0];
         stage_hist[k][SLOT_Y2] = stage_hist[k][SLOT_Y1];
         stage_hist[k][SLOT_Y1] = y[47:0];
         x = y;
      end
      // Scale, re-offset, wrap the top and gate against the window
      w = coef_mul(x, out_gain_q) + MID_LEVEL;
      if (w > FULL_LEVEL) begin
         w = w - FULL_LEVEL;
      end
      m = {48'd0, margin_reg};
      v = 0;
      if (!(w < 0 || w < (m <<< 16) || w > ((64'sd65536 - m) <<< 16))) begin
         v = w >>> 16;
         if (v > 64'sd65535) begin
            v = 64'sd65535;
         end
      end
      return music_on ? v[15:0] : 16'd0;
   endfunction

   // Write one register; the block is idle whenever this is called
   task automatic write_csr(hlwg_pkg::csr_index_type idx, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == hlwg_pkg::REG_MUSIC_ENABLE) begin
         music_on = value[0];
      end else begin
         margin_reg = value;
      end
      @(negedge clock);
   endtask

   // Offer one sample word in bursts with random gaps; predict on acceptance
   task automatic send_sample(logic [15:0] sample);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_drive_q.push_back(predict_drive(sample));
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_drive_q.size() != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   // Reset configuration: disabled, so the filter runs but every word is zero
   task automatic test_disabled_after_reset();
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      drain_results();
   endtask

   // Zero margin: only a negative level is gated, the top saturates
   task automatic test_zero_margin();
      write_csr(hlwg_pkg::REG_MUSIC_ENABLE, 16'd1);
      write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'd0);
      send_sample(16'h8000);
      send_sample(16'h8000);
      send_sample(16'hFFFF);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h0001);
      drain_results();
   endtask

   // Margins at and past half scale leave a single point or an empty window
   task automatic test_wide_margin();
      write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'd32768);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      drain_results();
      write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'd32769);
      send_sample(16'h8000);
      send_sample(16'h0000);
      drain_results();
      write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'hFFFF);
      send_sample(16'hFFFF);
      send_sample(16'h8000);
      drain_results();
   endtask

   // Hold the result side off long enough that the block stalls its input
   task automatic test_output_holdoff();
      int i;
      write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'd0);
      hold_off_cycles = 700;
      for (i = 0; i < 14; i++) begin
         send_sample(16'($urandom));
      end
      drain_results();
   endtask

   // Pause the sender mid-stream until every result is back
   task automatic test_sender_pause();
      int i;
      for (i = 0; i < 12; i++) begin
         send_sample(16'($urandom));
      end
      drain_results();
      for (i = 0; i < 12; i++) begin
         send_sample(16'($urandom));
      end
      drain_results();
   endtask

   // Level holds, ramps, noise and alternation under a series of settings
   task automatic test_random_levels();
      int          phase;
      int          quota;
      int          sent;
      int          kind;
      int          len;
      int          i;
      int          jitter;
      logic [15:0] level;
      logic [15:0] level_b;
      logic [15:0] sample;
      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin
               write_csr(hlwg_pkg::REG_MUSIC_ENABLE, 16'd1);
               write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'd8000);
            end
            1: write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'd0);
            2: write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'd32768);
            3: write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'hFFFF);
            4: begin
               write_csr(hlwg_pkg::REG_MUSIC_ENABLE, 16'd0);
               write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'($urandom_range(0, 32768)));
            end
            5: begin
               // only bit 0 of the enable write counts
               write_csr(hlwg_pkg::REG_MUSIC_ENABLE, 16'hFFFE);
               write_csr(hlwg_pkg::REG_WINDOW_MARGIN, 16'($urandom_range(0, 16000)));
            end
            default: begin
               write_csr(hlwg_pkg::REG_MUSIC_ENABLE, 16'($urandom) | 16'd1);
               write_csr(hlwg_pkg::REG_WINDOW_MARGIN, ($urandom_range(0, 7) == 0) ?
                         16'($urandom) : 16'($urandom_range(0, 32768)));
            end
         endcase
         quota = (phase == 2 || phase == 3) ? 40 : 180;
         sent  = 0;
         while (sent < quota) begin
            kind    = $urandom_range(0, 9);
            len     = $urandom_range(5, 120);
            level   = 16'($urandom);
            level_b = 16'($urandom);
            jitter  = 1 << $urandom_range(0, 9);
            for (i = 0; i < len && sent < quota; i++) begin
               case (kind)
                  6, 7: sample = 16'(int'(level) + (int'(level_b) - int'(level)) * i / len);
                  8: sample = 16'($urandom);
                  9: sample = i[0] ? 16'hFFFF : 16'h0000;
                  default: sample = level + 16'($urandom_range(0, jitter)) - 16'(jitter / 2);
               endcase
               send_sample(sample);
               sent++;
            end
         end
         drain_results();
      end
   endtask

   // Result side: random stalls, long free stretches, and a requested hold-off
   initial begin
      int n;
      int i;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end else begin
            case ($urandom_range(0, 5))
               0: begin
                  rsp_tready <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(negedge clock);
               end
               1: begin
                  rsp_tready <= 1'b0;
                  repeat ($urandom_range(20, 90)) @(negedge clock);
               end
               2: begin
                  n = $urandom_range(2, 40);
                  for (i = 0; i < n; i++) begin
                     rsp_tready <= i[0];
                     @(negedge clock);
                  end
               end
               default: begin
                  rsp_tready <= 1'b1;
                  repeat ($urandom_range(1, 200)) @(negedge clock);
               end
            endcase
         end
      end
   end

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drive_q.size() == 0) begin
            $display("%0t: drive_out with nothing expected: expected none, actual %0d",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_drive_q.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: drive_out mismatch: expected %0d, actual %0d",
                        $time, want, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   // Cycle limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = hlwg_pkg::REG_MUSIC_ENABLE;
      csr_wdata  = '0;
      reset_predictor();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_disabled_after_reset();
      test_zero_margin();
      test_wide_margin();
      test_output_holdoff();
      test_sender_pause();
      test_random_levels();

      drain_results();
      repeat (LATENCY_TAIL) @(negedge clock);
      if (expected_drive_q.size() != 0) begin
         $display("%0t: results still expected: expected 0, actual %0d",
                  $time, expected_drive_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
